// ===== hdl/region_copy_segmenter_assert.svh =====
// Assertion macros for the region copy segmenter.
// Expects clk and rst in the scope of the module that uses them.
`ifndef REGION_COPY_SEGMENTER_ASSERT_SVH
`define REGION_COPY_SEGMENTER_ASSERT_SVH
`ifndef SYNTHESIS
`define RCS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("region_copy_segmenter: check failed");
`define RCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("region_copy_segmenter: check failed");
`else
`define RCS_ASSERT(lbl, cond)
`define RCS_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ===== hdl/rcs_pkg.sv =====
// Shared constants for the region copy segmenter.
// No dependencies.
package rcs_pkg;

  localparam int CFG_W = 25;  // widest configuration register
  localparam int CNT_W = 6;   // region count register width
  localparam int LEN_W = 30;  // copy length width
  localparam int REG_W = 5;   // region index width
  localparam int IDX_W = 2;   // configuration register index width

  localparam logic [IDX_W-1:0] CFG_SRC_BYTES  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_DEST_BYTES = 2'd1;
  localparam logic [IDX_W-1:0] CFG_SRC_COUNT  = 2'd2;
  localparam logic [IDX_W-1:0] CFG_DEST_COUNT = 2'd3;

  localparam logic [CFG_W-1:0] RST_REGION_BYTES = 25'd4096;
  localparam logic [CNT_W-1:0] RST_REGION_COUNT = 6'd1;

endpackage

// ===== hdl/region_copy_segmenter.sv =====
// Region copy segmenter: splits a copy request into segments that cross no
// source or destination region boundary. Depends on rcs_pkg and the assert header.
//
// Usage:
//   Input channel (in_valid/in_ready, copy_length) takes one request at a time.
//   in_ready is high only while the block is idle. A zero-length request is
//   taken and produces nothing.
//   Output channel (out_valid/out_ready) carries one segment per beat with
//   source/destination region and offset, seg_bytes and last. A request that
//   exceeds either side's total size yields one beat with error and last set
//   and all other fields zero.
//   The shared multiplier forms the source total in ST_MUL_S and the
//   destination total in ST_MUL_D; ST_CHECK does the size check and loads an
//   error beat, else ST_SEG loads one segment per cycle while out_ready is high.
//   A request yields at most 2*MAX_REGIONS-1 segments.
//   A single output register holds the current beat; when the receiver
//   stalls the sequencer holds and resumes on the next taken beat.
//   Configuration (cfg_we, cfg_index, cfg_data) must be written by the user
//   only while idle; the block itself does not enforce this. Reset restores
//   region sizes of 4096 and counts of 1 and empties the output register.
`include "region_copy_segmenter_assert.svh"

module region_copy_segmenter #(
  parameter int MAX_REGIONS = 32,
  parameter int OFFSET_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rcs_pkg::IDX_W-1:0]     cfg_index,
  input  logic [rcs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rcs_pkg::LEN_W-1:0]     copy_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rcs_pkg::REG_W-1:0]     src_region,
  output logic [OFFSET_BITS-1:0]        src_offset,
  output logic [rcs_pkg::REG_W-1:0]     dest_region,
  output logic [OFFSET_BITS-1:0]        dest_offset,
  output logic [OFFSET_BITS:0]          seg_bytes,
  output logic                          last,
  output logic                          error
);

  localparam int SZ_W  = OFFSET_BITS + 1;
  localparam int CMP_W = (SZ_W > rcs_pkg::CFG_W) ? SZ_W : rcs_pkg::CFG_W;
  localparam int TOT_W = SZ_W + rcs_pkg::CNT_W;
  localparam int TL_W  = (TOT_W > rcs_pkg::LEN_W) ? TOT_W : rcs_pkg::LEN_W;
  localparam int RW    = (SZ_W > rcs_pkg::LEN_W) ? SZ_W : rcs_pkg::LEN_W;
  localparam logic [rcs_pkg::CNT_W-1:0] MAX_CNT = rcs_pkg::CNT_W'(MAX_REGIONS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_S = 3'd1;
  localparam logic [2:0] ST_MUL_D = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_SEG   = 3'd4;

  // configuration registers
  logic [rcs_pkg::CFG_W-1:0] src_bytes_cfg, dest_bytes_cfg;
  logic [rcs_pkg::CNT_W-1:0] src_count_cfg, dest_count_cfg;

  logic [2:0]                 state;
  logic [rcs_pkg::LEN_W-1:0]  rem;
  logic [TOT_W-1:0]           s_total, d_total;
  logic [rcs_pkg::REG_W-1:0]  si, di;
  logic [OFFSET_BITS-1:0]     so, dof;

  logic [SZ_W-1:0]            sb, db;
  logic [rcs_pkg::CNT_W-1:0]  sc, dc;
  logic [SZ_W-1:0]            mul_a;
  logic [rcs_pkg::CNT_W-1:0]  mul_b;
  logic [TOT_W-1:0]           prod;
  logic                       too_big;
  logic [SZ_W-1:0]            s_room, d_room, room;
  logic [RW-1:0]              seg_rw;
  logic [SZ_W-1:0]            seg;
  logic                       seg_last;
  logic [SZ_W-1:0]            so_sum, do_sum;
  logic                       out_free;
  logic                       out_load;

  function automatic logic [SZ_W-1:0] clamp_size(input logic [rcs_pkg::CFG_W-1:0] v);
    logic [CMP_W-1:0] ext;
    logic [CMP_W-1:0] top;
    logic [CMP_W-1:0] res;
    ext = CMP_W'(v);
    top = CMP_W'(1) << OFFSET_BITS;
    if (ext == '0) begin
      res = CMP_W'(1);
    end else if (ext > top) begin
      res = top;
    end else begin
      res = ext;
    end
    return SZ_W'(res);
  endfunction

  assign sb = clamp_size(src_bytes_cfg);
  assign db = clamp_size(dest_bytes_cfg);
  assign sc = (src_count_cfg > MAX_CNT) ? MAX_CNT : src_count_cfg;
  assign dc = (dest_count_cfg > MAX_CNT) ? MAX_CNT : dest_count_cfg;

  // shared multiplier: source total, then destination total
  assign mul_a = (state == ST_MUL_D) ? db : sb;
  assign mul_b = (state == ST_MUL_D) ? dc : sc;
  assign prod  = TOT_W'(mul_a) * TOT_W'(mul_b);

  assign too_big = (TL_W'(rem) > TL_W'(s_total)) || (TL_W'(rem) > TL_W'(d_total));

  // segment length: nearest boundary on either side or end of request
  assign s_room   = sb - SZ_W'(so);
  assign d_room   = db - SZ_W'(dof);
  assign room     = (s_room < d_room) ? s_room : d_room;
  assign seg_rw   = (RW'(room) < RW'(rem)) ? RW'(room) : RW'(rem);
  assign seg      = SZ_W'(seg_rw);
  assign seg_last = (RW'(rem) == seg_rw);
  assign so_sum   = SZ_W'(so) + seg;
  assign do_sum   = SZ_W'(dof) + seg;

  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && (((state == ST_CHECK) && too_big) || (state == ST_SEG));
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_bytes_cfg  <= rcs_pkg::RST_REGION_BYTES;
      dest_bytes_cfg <= rcs_pkg::RST_REGION_BYTES;
      src_count_cfg  <= rcs_pkg::RST_REGION_COUNT;
      dest_count_cfg <= rcs_pkg::RST_REGION_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcs_pkg::CFG_SRC_BYTES:  src_bytes_cfg  <= cfg_data;
        rcs_pkg::CFG_DEST_BYTES: dest_bytes_cfg <= cfg_data;
        rcs_pkg::CFG_SRC_COUNT:  src_count_cfg  <= cfg_data[rcs_pkg::CNT_W-1:0];
        rcs_pkg::CFG_DEST_COUNT: dest_count_cfg <= cfg_data[rcs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // load a new beat, else drop the one just taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          // zero-length requests are dropped here
          if (in_valid && copy_length != '0) begin
            state <= ST_MUL_S;
          end
        end
        ST_MUL_S: state <= ST_MUL_D;
        ST_MUL_D: state <= ST_CHECK;
        ST_CHECK: begin
          if (too_big) begin
            if (out_free) begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_SEG;
          end
        end
        ST_SEG: begin
          if (out_free && seg_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath: request walk and output register
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        rem <= copy_length;
        si  <= '0;
        di  <= '0;
        so  <= '0;
        dof <= '0;
      end
      ST_MUL_S: s_total <= prod;
      ST_MUL_D: d_total <= prod;
      ST_CHECK: begin
        if (too_big && out_free) begin
          src_region  <= '0;
          src_offset  <= '0;
          dest_region <= '0;
          dest_offset <= '0;
          seg_bytes   <= '0;
          last        <= 1'b1;
          error       <= 1'b1;
        end
      end
      ST_SEG: begin
        if (out_free) begin
          src_region  <= si;
          src_offset  <= so;
          dest_region <= di;
          dest_offset <= dof;
          seg_bytes   <= seg;
          last        <= seg_last;
          error       <= 1'b0;
          rem         <= rem - rcs_pkg::LEN_W'(seg_rw);
          // advance to the next region on a boundary hit
          if (so_sum == sb) begin
            so <= '0;
            si <= si + rcs_pkg::REG_W'(1);
          end else begin
            so <= OFFSET_BITS'(so_sum);
          end
          if (do_sum == db) begin
            dof <= '0;
            di  <= di + rcs_pkg::REG_W'(1);
          end else begin
            dof <= OFFSET_BITS'(do_sum);
          end
        end
      end
      default: ;
    endcase
  end

  `RCS_ASSERT_IMPL(a_seg_rem_nonzero, state == ST_SEG, rem != '0)
  `RCS_ASSERT_IMPL(a_seg_offsets_in_region, state == ST_SEG, (SZ_W'(so) < sb) && (SZ_W'(dof) < db))
  `RCS_ASSERT_IMPL(a_error_is_last, out_valid && error, last && seg_bytes == '0)
  `RCS_ASSERT_IMPL(a_segment_nonempty, out_valid && !error, seg_bytes != '0)
  `RCS_ASSERT(a_ready_only_idle, !in_ready || state == ST_IDLE)

endmodule

// ===== dv/region_copy_segmenter_tb.sv =====
// Self-checking testbench for region_copy_segmenter: directed and random copy requests,
// with segment predictions checked beat by beat. Depends on rcs_pkg and the block RTL.
module region_copy_segmenter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFF_W = 24;
  localparam int SEG_CAP = 63;
  localparam longint unsigned SIZE_TOP = 64'd1 << OFF_W;
  localparam longint unsigned MAX_REGIONS = 32;

  typedef struct packed {
    logic [rcs_pkg::REG_W-1:0] src_region;
    logic [OFF_W-1:0]          src_offset;
    logic [rcs_pkg::REG_W-1:0] dest_region;
    logic [OFF_W-1:0]          dest_offset;
    logic [OFF_W:0]            seg_bytes;
    logic                      last;
    logic                      error;
  } segment_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [rcs_pkg::IDX_W-1:0] cfg_index = rcs_pkg::CFG_SRC_BYTES;
  logic [rcs_pkg::CFG_W-1:0] cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [rcs_pkg::LEN_W-1:0] copy_length = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [rcs_pkg::REG_W-1:0] src_region;
  logic [OFF_W-1:0]          src_offset;
  logic [rcs_pkg::REG_W-1:0] dest_region;
  logic [OFF_W-1:0]          dest_offset;
  logic [OFF_W:0]            seg_bytes;
  logic                      last;
  logic                      error;

  // Shadow copy of the configuration registers
  logic [rcs_pkg::CFG_W-1:0] src_bytes_cfg = rcs_pkg::RST_REGION_BYTES;
  logic [rcs_pkg::CFG_W-1:0] dest_bytes_cfg = rcs_pkg::RST_REGION_BYTES;
  logic [rcs_pkg::CNT_W-1:0] src_count_cfg = rcs_pkg::RST_REGION_COUNT;
  logic [rcs_pkg::CNT_W-1:0] dest_count_cfg = rcs_pkg::RST_REGION_COUNT;

  segment_t pending_segs[$];
  int       fail_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  // Long receiver hold-off, requested by the test and counted by the receiver
  int hold_id = 0;
  int hold_seen = 0;
  int hold_len = 0;
  int hold_left = 0;

  region_copy_segmenter dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .copy_length(copy_length),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .src_region (src_region),
    .src_offset (src_offset),
    .dest_region(dest_region),
    .dest_offset(dest_offset),
    .seg_bytes  (seg_bytes),
    .last       (last),
    .error      (error)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint unsigned eff_size(input logic [rcs_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (64'(v) > SIZE_TOP) return SIZE_TOP;
    return 64'(v);
  endfunction

  function automatic longint unsigned eff_count(input logic [rcs_pkg::CNT_W-1:0] v);
    return (64'(v) > MAX_REGIONS) ? MAX_REGIONS : 64'(v);
  endfunction

  function automatic longint unsigned src_total();
    return eff_size(src_bytes_cfg) * eff_count(src_count_cfg);
  endfunction

  function automatic longint unsigned dest_total();
    return eff_size(dest_bytes_cfg) * eff_count(dest_count_cfg);
  endfunction

  // Append one expected segment to the scoreboard
  function automatic void add_expected(input segment_t s);
    pending_segs = {pending_segs, s};
  endfunction

  // Queue the segments a request of len bytes produces under the current setting
  function automatic void predict_segments(input logic [rcs_pkg::LEN_W-1:0] len);
    longint unsigned sb, db, pos, si, di, stop;
    int       n;
    segment_t s;
    sb = eff_size(src_bytes_cfg);
    db = eff_size(dest_bytes_cfg);
    if (len == 0) return;
    if (64'(len) > src_total() || 64'(len) > dest_total()) begin
      s = '0;
      s.last = 1'b1;
      s.error = 1'b1;
      add_expected(s);
      return;
    end
    pos = 0;
    n = 0;
    while (pos < 64'(len) && n < SEG_CAP) begin
      si = pos / sb;
      di = pos / db;
      stop = (si + 1) * sb;
      if ((di + 1) * db < stop) stop = (di + 1) * db;
      if (64'(len) < stop) stop = 64'(len);
      s.src_region = si[rcs_pkg::REG_W-1:0];
      s.src_offset = OFF_W'(pos - si * sb);
      s.dest_region = di[rcs_pkg::REG_W-1:0];
      s.dest_offset = OFF_W'(pos - di * db);
      s.seg_bytes = (OFF_W + 1)'(stop - pos);
      s.last = (stop >= 64'(len));
      s.error = 1'b0;
      add_expected(s);
      n++;
      pos = stop;
    end
  endfunction

  function automatic void check_field(input string name, input longint unsigned exp_v,
                                      input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic void check_beat();
    segment_t s;
    if (pending_segs.size() == 0) begin
      $error("output beat with no segment pending");
      fail_count++;
      return;
    end
    s = pending_segs.pop_front();
    check_field("src_region", 64'(s.src_region), 64'(src_region));
    check_field("src_offset", 64'(s.src_offset), 64'(src_offset));
    check_field("dest_region", 64'(s.dest_region), 64'(dest_region));
    check_field("dest_offset", 64'(s.dest_offset), 64'(dest_offset));
    check_field("seg_bytes", 64'(s.seg_bytes), 64'(seg_bytes));
    check_field("last", 64'(s.last), 64'(last));
    check_field("error", 64'(s.error), 64'(error));
  endfunction

  // Receiver: check each taken beat, then pick out_ready for the next edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_beat();
    if (hold_id != hold_seen) begin
      hold_seen <= hold_id;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer one request; return at the edge that takes it, valid still high
  task automatic send_request(input logic [rcs_pkg::LEN_W-1:0] len);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    copy_length <= len;
    predict_segments(len);
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every pending segment, then let a busy block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Only while idle; never called back to back
  task automatic configure(input logic [rcs_pkg::CFG_W-1:0] sbytes,
                           input logic [rcs_pkg::CFG_W-1:0] dbytes,
                           input logic [rcs_pkg::CFG_W-1:0] scount,
                           input logic [rcs_pkg::CFG_W-1:0] dcount);
    cfg_we <= 1'b1;
    cfg_index <= rcs_pkg::CFG_SRC_BYTES;
    cfg_data <= sbytes;
    @(posedge clk);
    cfg_index <= rcs_pkg::CFG_DEST_BYTES;
    cfg_data <= dbytes;
    @(posedge clk);
    cfg_index <= rcs_pkg::CFG_SRC_COUNT;
    cfg_data <= scount;
    @(posedge clk);
    cfg_index <= rcs_pkg::CFG_DEST_COUNT;
    cfg_data <= dcount;
    @(posedge clk);
    cfg_we <= 1'b0;
    src_bytes_cfg = sbytes;
    dest_bytes_cfg = dbytes;
    src_count_cfg = scount[rcs_pkg::CNT_W-1:0];
    dest_count_cfg = dcount[rcs_pkg::CNT_W-1:0];
  endtask

  function automatic logic [rcs_pkg::CFG_W-1:0] pick_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return rcs_pkg::CFG_W'($urandom_range(1, 64));
    if (pick < 70) return '0;
    if (pick < 80) begin
      return rcs_pkg::CFG_W'($urandom_range((1 << OFF_W) - 2, (1 << rcs_pkg::CFG_W) - 1));
    end
    if (pick < 90) return rcs_pkg::CFG_W'($urandom_range(65, 5000));
    return rcs_pkg::CFG_W'($urandom());
  endfunction

  function automatic logic [rcs_pkg::CFG_W-1:0] pick_count();
    logic [rcs_pkg::CFG_W-1:0] v;
    int pick;
    pick = $urandom_range(0, 99);
    v = ($urandom_range(0, 1) != 0) ? rcs_pkg::CFG_W'($urandom()) : '0;
    if (pick < 75) v[rcs_pkg::CNT_W-1:0] = rcs_pkg::CNT_W'($urandom_range(1, 32));
    else if (pick < 85) v[rcs_pkg::CNT_W-1:0] = '0;
    else v[rcs_pkg::CNT_W-1:0] = rcs_pkg::CNT_W'($urandom_range(33, 63));
    return v;
  endfunction

  // Mostly requests that fit, plus the exact total, one past it, zero and noise
  function automatic logic [rcs_pkg::LEN_W-1:0] pick_length();
    longint unsigned lim;
    int pick;
    lim = (src_total() < dest_total()) ? src_total() : dest_total();
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 16 || lim == 0) return rcs_pkg::LEN_W'($urandom());
    if (pick < 26) return rcs_pkg::LEN_W'(lim);
    if (pick < 34) return rcs_pkg::LEN_W'(lim + 1);
    if (pick < 60) return rcs_pkg::LEN_W'($urandom_range(1, (lim < 200) ? int'(lim) : 200));
    return rcs_pkg::LEN_W'($urandom_range(1, int'(lim)));
  endfunction

  task automatic test_reset_defaults();
    send_request(0);
    send_request(1);
    send_request(2048);
    send_request(4096);
    send_request(4097);
    send_request({rcs_pkg::LEN_W{1'b1}});
    drain();
  endtask

  task automatic test_size_extremes();
    configure('0, '0, 32, 32);
    send_request(1);
    send_request(32);
    send_request(33);
    drain();
    configure({rcs_pkg::CFG_W{1'b1}}, 25'h1000000, {19'h7ffff, 6'd63}, 40);
    send_request(30'h20000000);
    send_request(30'h20000001);
    send_request(30'h01000005);
    drain();
  endtask

  task automatic test_boundary_mix();
    // Region sizes 32 and 33 share no boundary below 1024: 63 segments
    configure(32, 33, 32, 32);
    send_request(1024);
    send_request(1023);
    send_request(1056);
    send_request(500);
    drain();
    configure(3, 5, 32, 20);
    send_request(60);
    send_request(97);
    drain();
  endtask

  task automatic test_zero_count();
    configure(4096, 4096, 0, 7);
    send_request(0);
    send_request(1);
    drain();
    configure(16, 16, 5, 0);
    send_request(0);
    send_request(80);
    drain();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int items);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < items; i++) begin
      if (i % 15 == 0) begin
        drain();
        configure(pick_size(), pick_size(), pick_count(), pick_count());
      end
      send_request(pick_length());
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(32, 33, 32, 32);
    hold_len <= 400;
    hold_id <= hold_id + 1;
    for (int i = 0; i < 6; i++) send_request(rcs_pkg::LEN_W'(1024 - 64 * i));
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_size_extremes();
    test_boundary_mix();
    test_zero_count();
    test_random_traffic(0, 0, 75);
    test_random_traffic(56, 0, 75);
    test_random_traffic(0, 56, 75);
    test_random_traffic(26, 26, 75);
    test_backpressure();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== region_copy_segmenter.f =====
+incdir+hdl
hdl/rcs_pkg.sv
hdl/region_copy_segmenter.sv
dv/region_copy_segmenter_tb.sv
